[hdl/stc_pkg.sv]
// Shared types and constants for the SVG unsupported-tag counter.
// No dependencies; used by every module under hdl/.
package stc_pkg;

    // Window of lowered bytes, entry 0 is the most recent byte
    localparam int WIN_DEPTH = 9;
    typedef logic [WIN_DEPTH-1:0][7:0] t_window;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int OUT_WIDTH = 16;
    localparam logic [31:0] OUT_MAX = 32'd65535;

    // Characters the matcher looks for
    localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // Tag names, lower case, first character in the top byte
    localparam logic [31:0] NM_TEXT     = "text";
    localparam logic [39:0] NM_TSPAN    = "tspan";
    localparam logic [39:0] NM_IMAGE    = "image";
    localparam logic [23:0] NM_USE      = "use";
    localparam logic [63:0] NM_CLIPPATH = "clippath";
    localparam logic [31:0] NM_MASK     = "mask";
    localparam logic [47:0] NM_FILTER   = "filter";
    localparam logic [55:0] NM_PATTERN  = "pattern";

    // One flag per counted category
    typedef struct packed {
        logic text_hit;
        logic image_hit;
        logic use_hit;
        logic clip_hit;
        logic filter_hit;
        logic pattern_hit;
    } t_hits;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

endpackage

[hdl/stc_window.sv]
// Byte window and parallel tag-name compare for the tag counter.
// Depends on stc_pkg.
module stc_window (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_advance,
    input  logic           i_clear,
    input  logic [7:0]     i_byte,
    output stc_pkg::t_hits o_hits
);

    stc_pkg::t_window r_win;
    stc_pkg::t_window n_win;
    logic             term;

    // Shift in the lowered byte, or empty the window at document end
    always_comb begin
        n_win = r_win;
        if (i_advance) begin
            if (i_clear) begin
                n_win = '0;
            end else begin
                n_win = {r_win[stc_pkg::WIN_DEPTH-2:0], stc_pkg::lower_ascii(i_byte)};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else begin
            r_win <= n_win;
        end
    end

    // The current byte completes a tag when it is a terminator
    assign term = (i_byte == stc_pkg::CH_GT)    || (i_byte == stc_pkg::CH_SLASH) ||
                  (i_byte == stc_pkg::CH_SPACE) || (i_byte == stc_pkg::CH_TAB)   ||
                  (i_byte == stc_pkg::CH_LF)    || (i_byte == stc_pkg::CH_CR);

    // '<' then name, read backward from the newest entry
    always_comb begin
        o_hits.text_hit = term &&
            (((r_win[4] == stc_pkg::CH_LT) && (r_win[3:0] == stc_pkg::NM_TEXT)) ||
             ((r_win[5] == stc_pkg::CH_LT) && (r_win[4:0] == stc_pkg::NM_TSPAN)));
        o_hits.image_hit = term &&
            (r_win[5] == stc_pkg::CH_LT) && (r_win[4:0] == stc_pkg::NM_IMAGE);
        o_hits.use_hit = term &&
            (r_win[3] == stc_pkg::CH_LT) && (r_win[2:0] == stc_pkg::NM_USE);
        o_hits.clip_hit = term &&
            (((r_win[8] == stc_pkg::CH_LT) && (r_win[7:0] == stc_pkg::NM_CLIPPATH)) ||
             ((r_win[4] == stc_pkg::CH_LT) && (r_win[3:0] == stc_pkg::NM_MASK)));
        o_hits.filter_hit = term &&
            (r_win[6] == stc_pkg::CH_LT) && (r_win[5:0] == stc_pkg::NM_FILTER);
        o_hits.pattern_hit = term &&
            (r_win[7] == stc_pkg::CH_LT) && (r_win[6:0] == stc_pkg::NM_PATTERN);
    end

endmodule

[hdl/stc_counters.sv]
// Six saturating category counters for the tag counter.
// Depends on stc_pkg.
module stc_counters #(
    parameter int COUNT_WIDTH = stc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_advance,
    input  logic                        i_clear,
    input  stc_pkg::t_hits              i_hits,
    output logic [5:0][COUNT_WIDTH-1:0] o_next,
    output logic                        o_all_zero
);

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [5:0][COUNT_WIDTH-1:0] r_cnt;
    logic [5:0]                  hit_vec;

    assign hit_vec = {i_hits.text_hit, i_hits.image_hit, i_hits.use_hit,
                      i_hits.clip_hit, i_hits.filter_hit, i_hits.pattern_hit};

    // Counts including the current byte, held at the maximum
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            o_next[k] = r_cnt[k];
            if (hit_vec[k] && (r_cnt[k] != CNT_MAX)) begin
                o_next[k] = r_cnt[k] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_advance) begin
            if (i_clear) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= o_next;
            end
        end
    end

    assign o_all_zero = (r_cnt == '0);

endmodule

[hdl/svg_unsupported_tag_counter_core.sv]
// Top level of the SVG unsupported-tag counter: input register, window,
// counters and result register. Depends on stc_pkg, stc_window, stc_counters.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+-----------------------------------------
//  in      | i_valid | o_ready | i_doc_byte, i_last_byte
//  out     | o_valid | i_ready | o_text_tags .. o_pattern_tags (16 b each)
//
// One byte per clock sustained unless a last byte is held by the output side;
// the compare and counter update happen as the byte leaves the input register.
// The result for a document is loaded into the output register as its last
// byte leaves the input register. Only a last byte waits on a full,
// stalled output register; all other bytes pass regardless of output stalls.
// Reset clears the window, counters and both valid flags.
module svg_unsupported_tag_counter_core #(
    parameter int COUNT_WIDTH = stc_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_doc_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_text_tags,
    output logic [15:0] o_image_tags,
    output logic [15:0] o_use_tags,
    output logic [15:0] o_clip_tags,
    output logic [15:0] o_filter_tags,
    output logic [15:0] o_pattern_tags
);

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       advance;
    logic       out_free;
    logic       all_zero;

    stc_pkg::t_hits              hits;
    logic [5:0][COUNT_WIDTH-1:0] next_cnt;
    logic [5:0][15:0]            sat_cnt;
    logic [5:0][15:0]            r_out;

    // Output register can take a result when empty or being drained
    assign out_free = !o_valid || i_ready;
    assign advance  = r_in_valid && (!r_last || out_free);
    assign o_ready  = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_doc_byte;
            r_last <= i_last_byte;
        end
    end

    stc_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_clear   (r_last),
        .i_byte    (r_byte),
        .o_hits    (hits)
    );

    stc_counters #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_counters (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_clear    (r_last),
        .i_hits     (hits),
        .o_next     (next_cnt),
        .o_all_zero (all_zero)
    );

    // Clamp each count to the 16-bit output range
    always_comb begin
        logic [31:0] v;
        v = '0;
        for (int k = 0; k < 6; k++) begin
            v = 32'(next_cnt[k]);
            sat_cnt[k] = (v > stc_pkg::OUT_MAX) ? 16'hFFFF : v[15:0];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (advance && r_last) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_out <= sat_cnt;
        end
    end

    assign o_text_tags    = r_out[5];
    assign o_image_tags   = r_out[4];
    assign o_use_tags     = r_out[3];
    assign o_clip_tags    = r_out[2];
    assign o_filter_tags  = r_out[1];
    assign o_pattern_tags = r_out[0];

`ifndef NO_ASSERTIONS
    // A byte that is not last never waits on the output side
    a_nonlast_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_last) |-> advance)
        else $error("non-last byte stalled in input register");

    // Last byte leaving the input register produces a result
    a_last_makes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_last) |=> o_valid)
        else $error("last byte did not produce a result");

    // Counters start over after a document ends
    a_counts_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_last) |=> all_zero)
        else $error("counters not cleared after document end");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !(advance && r_last))
        else $error("result overwritten while stalled");
`endif

endmodule

[sim/stc_summary_checker.sv]
`timescale 1ns / 100ps
// Checker for the SVG unsupported-tag counter: watches the byte and result channels,
// predicts the tag counts of each document and compares them with the block's results.
// Depends on stc_pkg.
module stc_summary_checker #(
    parameter int COUNT_WIDTH = stc_pkg::COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_doc_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_text_tags,
    input  logic [15:0] i_image_tags,
    input  logic [15:0] i_use_tags,
    input  logic [15:0] i_clip_tags,
    input  logic [15:0] i_filter_tags,
    input  logic [15:0] i_pattern_tags,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_docs_checked,
    output int          o_bytes_seen
);

    // Counted categories, in the order of the result fields
    typedef enum int {
        CAT_TEXT,
        CAT_IMAGE,
        CAT_USE,
        CAT_CLIP,
        CAT_FILTER,
        CAT_PATTERN
    } t_category;
    localparam int CAT_NUM = 6;

    typedef logic [CAT_NUM-1:0][stc_pkg::OUT_WIDTH-1:0] t_tallies;

    stc_pkg::t_window       recent_bytes;
    logic [COUNT_WIDTH-1:0] tag_count [CAT_NUM];
    t_tallies               expected_summaries [$];

    function automatic string field_name(input int c);
        case (c)
            CAT_TEXT:   return "text_tags";
            CAT_IMAGE:  return "image_tags";
            CAT_USE:    return "use_tags";
            CAT_CLIP:   return "clip_tags";
            CAT_FILTER: return "filter_tags";
            default:    return "pattern_tags";
        endcase
    endfunction

    function automatic logic is_terminator(input logic [7:0] b);
        return b == stc_pkg::CH_GT || b == stc_pkg::CH_SLASH || b == stc_pkg::CH_SPACE ||
               b == stc_pkg::CH_TAB || b == stc_pkg::CH_LF || b == stc_pkg::CH_CR;
    endfunction

    // Only ASCII capitals are folded
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        if (b >= stc_pkg::CH_UP_A && b <= stc_pkg::CH_UP_Z) begin
            return b + 8'd32;
        end
        return b;
    endfunction

    // Window ends in '<' plus the name; name char j sits at recent_bytes[len-1-j]
    function automatic logic name_closed(input logic [63:0] name, input int len);
        if (recent_bytes[len] != stc_pkg::CH_LT) begin
            return 1'b0;
        end
        for (int j = 0; j < len; j++) begin
            if (recent_bytes[j] != name[j*8 +: 8]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void bump(input t_category c);
        if (tag_count[c] != '1) begin
            tag_count[c] = tag_count[c] + 1'b1;
        end
    endfunction

    function automatic void clear_document();
        recent_bytes = '0;
        for (int c = 0; c < CAT_NUM; c++) begin
            tag_count[c] = '0;
        end
    endfunction

    // Queue one expected summary behind those already waiting
    function automatic void queue_summary(input t_tallies s);
        expected_summaries.insert(expected_summaries.size(), s);
    endfunction

    // Advance the prediction by one byte; a last byte closes the document
    function automatic void scan_byte(input logic [7:0] b, input logic last);
        t_tallies    summary;
        logic [63:0] wide;
        if (is_terminator(b)) begin
            if (name_closed(stc_pkg::NM_TEXT, 4))     bump(CAT_TEXT);
            if (name_closed(stc_pkg::NM_TSPAN, 5))    bump(CAT_TEXT);
            if (name_closed(stc_pkg::NM_IMAGE, 5))    bump(CAT_IMAGE);
            if (name_closed(stc_pkg::NM_USE, 3))      bump(CAT_USE);
            if (name_closed(stc_pkg::NM_CLIPPATH, 8)) bump(CAT_CLIP);
            if (name_closed(stc_pkg::NM_MASK, 4))     bump(CAT_CLIP);
            if (name_closed(stc_pkg::NM_FILTER, 6))   bump(CAT_FILTER);
            if (name_closed(stc_pkg::NM_PATTERN, 7))  bump(CAT_PATTERN);
        end
        recent_bytes = {recent_bytes[stc_pkg::WIN_DEPTH-2:0], fold_case(b)};
        if (last) begin
            for (int c = 0; c < CAT_NUM; c++) begin
                wide = 64'(tag_count[c]);
                summary[c] = (wide > 64'(stc_pkg::OUT_MAX))
                           ? stc_pkg::OUT_MAX[stc_pkg::OUT_WIDTH-1:0]
                           : wide[stc_pkg::OUT_WIDTH-1:0];
            end
            queue_summary(summary);
            clear_document();
        end
    endfunction

    function automatic void check_summary(input t_tallies seen);
        t_tallies want;
        if (expected_summaries.size() == 0) begin
            $error("result transaction with no document summary pending");
            o_fail_count++;
            return;
        end
        want = expected_summaries.pop_front();
        for (int c = 0; c < CAT_NUM; c++) begin
            if (want[c] !== seen[c]) begin
                $error("%s: expected %0d, actual %0d", field_name(c), want[c], seen[c]);
                o_fail_count++;
            end
        end
        o_docs_checked++;
    endfunction

    // Results are checked before the same edge's byte is folded in
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_document();
            expected_summaries.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                check_summary({i_pattern_tags, i_filter_tags, i_clip_tags,
                               i_use_tags, i_image_tags, i_text_tags});
            end
            if (i_in_valid && i_in_ready) begin
                scan_byte(i_doc_byte, i_last_byte);
                o_bytes_seen++;
            end
        end
        o_pending <= expected_summaries.size();
    end

endmodule

[sim/tb_svg_unsupported_tag_counter_core.sv]
`timescale 1ns / 100ps
// Testbench top for svg_unsupported_tag_counter_core: generates documents and
// handshake idling, gives the verdict. Depends on stc_pkg, the core and stc_summary_checker.
module tb_svg_unsupported_tag_counter_core;

    localparam int RANDOM_BYTES    = 1000;
    localparam int TAIL_REPEATS    = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int HOLD_AFTER_DOCS = 10;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200_000;

    typedef enum int {
        TOK_TAG,
        TOK_NEAR,
        TOK_NOISE,
        TOK_BARE
    } t_token;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_doc_byte  = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [15:0] o_text_tags;
    logic [15:0] o_image_tags;
    logic [15:0] o_use_tags;
    logic [15:0] o_clip_tags;
    logic [15:0] o_filter_tags;
    logic [15:0] o_pattern_tags;

    int          fail_count;
    int          pending;
    int          docs_checked;
    int          bytes_seen;
    int          bytes_sent = 0;
    int          docs_sent  = 0;
    bit          quiet      = 1'b0;
    bit          hold_done  = 1'b0;
    int unsigned cycle_cnt  = 0;
    logic [7:0]  doc_q [$];

    svg_unsupported_tag_counter_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_doc_byte     (i_doc_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_text_tags    (o_text_tags),
        .o_image_tags   (o_image_tags),
        .o_use_tags     (o_use_tags),
        .o_clip_tags    (o_clip_tags),
        .o_filter_tags  (o_filter_tags),
        .o_pattern_tags (o_pattern_tags)
    );

    stc_summary_checker u_summary_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_doc_byte     (i_doc_byte),
        .i_last_byte    (i_last_byte),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_text_tags    (o_text_tags),
        .i_image_tags   (o_image_tags),
        .i_use_tags     (o_use_tags),
        .i_clip_tags    (o_clip_tags),
        .i_filter_tags  (o_filter_tags),
        .i_pattern_tags (o_pattern_tags),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_docs_checked (docs_checked),
        .o_bytes_seen   (bytes_seen)
    );

    // 12 ns clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic string tag_name(input int k);
        case (k)
            0:       return "text";
            1:       return "tspan";
            2:       return "image";
            3:       return "use";
            4:       return "clipPath";
            5:       return "mask";
            6:       return "filter";
            default: return "pattern";
        endcase
    endfunction

    function automatic logic [7:0] pick_terminator();
        case ($urandom_range(0, 5))
            0:       return stc_pkg::CH_GT;
            1:       return stc_pkg::CH_SLASH;
            2:       return stc_pkg::CH_SPACE;
            3:       return stc_pkg::CH_TAB;
            4:       return stc_pkg::CH_LF;
            default: return stc_pkg::CH_CR;
        endcase
    endfunction

    // Add one byte at the end of the document being built
    function automatic void append_byte(input logic [7:0] b);
        doc_q.insert(doc_q.size(), b);
    endfunction

    function automatic void push_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            append_byte(s[i]);
        end
    endfunction

    // First keep chars of a name, each letter in random case
    function automatic void push_name(input string s, input int keep);
        logic [7:0] c;
        for (int i = 0; i < keep; i++) begin
            c = s[i];
            if ((c | stc_pkg::CASE_BIT) >= "a" && (c | stc_pkg::CASE_BIT) <= "z" &&
                $urandom_range(0, 1) == 1) begin
                c = c ^ stc_pkg::CASE_BIT;
            end
            append_byte(c);
        end
    endfunction

    // Half complete tags; the rest near misses, raw noise and names without '<'
    function automatic void push_token();
        t_token kind;
        int     r;
        string  nm;
        r    = $urandom_range(0, 9);
        kind = (r < 5) ? TOK_TAG : (r < 7) ? TOK_NEAR : (r < 9) ? TOK_NOISE : TOK_BARE;
        nm   = tag_name($urandom_range(0, 7));
        case (kind)
            TOK_TAG: begin
                append_byte(stc_pkg::CH_LT);
                push_name(nm, nm.len());
                append_byte(pick_terminator());
            end
            TOK_NEAR: begin
                append_byte(stc_pkg::CH_LT);
                push_name(nm, $urandom_range(1, nm.len()));
                append_byte(8'($urandom_range(0, 255)));
            end
            TOK_NOISE: begin
                repeat ($urandom_range(1, 5)) append_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                push_name(nm, nm.len());
                append_byte(pick_terminator());
            end
        endcase
    endfunction

    // One input transaction; valid holds until accepted
    task automatic send_byte(input logic [7:0] b, input logic last, input bit gaps);
        if (gaps && !quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_doc_byte  <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_doc(input bit gaps);
        for (int i = 0; i < doc_q.size(); i++) begin
            send_byte(doc_q[i], i == doc_q.size() - 1, gaps);
        end
        docs_sent++;
        doc_q.delete();
    endtask

    // Result side: random stalls, one long hold-off, none at the end
    initial begin
        int hold;
        forever begin
            if (quiet) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else if (!hold_done && docs_sent >= HOLD_AFTER_DOCS) begin
                i_ready <= 1'b0;
                hold = 0;
                while (hold < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    hold++;
                end
                hold_done = 1'b1;
            end else begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_ready <= 1'b1;
                repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 6)) @(posedge i_clk);
            end
        end
    end

    // Watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        string tail;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // tag cut off by the end of the document, then a lone terminator
        // that must not complete it across the document boundary
        push_str("<USE");
        send_doc(1'b0);
        push_str(">");
        send_doc(1'b0);
        // byte extremes, then a tag closed by the final byte itself
        append_byte(8'h00);
        append_byte(8'hFF);
        push_str("<mask <pattern>");
        send_doc(1'b0);

        // random documents, some ending in an unterminated tag
        while (bytes_sent < RANDOM_BYTES) begin
            repeat ($urandom_range(1, 4)) push_token();
            if ($urandom_range(0, 7) == 0) begin
                append_byte(stc_pkg::CH_LT);
                tail = tag_name($urandom_range(0, 7));
                push_name(tail, tail.len());
            end
            send_doc($urandom_range(0, 2) != 0);
        end

        // closing document, back to back with the output always ready
        quiet = 1'b1;
        for (int r = 0; r < TAIL_REPEATS; r++) begin
            push_str("<use/");
        end
        push_str("<Text>");
        send_doc(1'b0);

        // drain: let the last expectation register in pending before polling it
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d bytes in %0d documents, %0d results compared.",
                 bytes_seen, docs_sent, docs_checked);
        $display("Included mixed-case tags, all terminators, near misses, cut-off tags, a long stall.");
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
